// ===== sv/heater_status_frame_receiver_macros.svh =====
// Assertion macros shared by the heater status frame receiver modules.
// Depends on nothing; included by every module that carries assertions.
`ifndef HEATER_STATUS_FRAME_RECEIVER_MACROS_SVH
`define HEATER_STATUS_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsfr same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsfr next-cycle check failed");

`endif

// ===== sv/hsfr_pkg.sv =====
// Shared types and byte codes of the heater status frame receiver.
// Depends on nothing; used by hsfr_parser and the top level.
package hsfr_pkg;

    localparam logic [7:0] BYTE_START     = 8'h5A;
    localparam logic [7:0] BYTE_END       = 8'h5B;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] STATUS_TAG     = 8'hC9;
    localparam logic [7:0] MODE_OFF_CODE  = 8'h00;
    localparam logic [7:0] MODE_HEAT_CODE = 8'h01;

    // Byte positions inside a stored frame
    localparam int POS_TAG     = 4;
    localparam int POS_TARGET  = 6;
    localparam int POS_CURRENT = 7;
    localparam int POS_MODE    = 9;
    localparam int POS_ACTION  = 11;

    typedef struct packed {
        logic [7:0] target_temp;
        logic [7:0] current_temp;
        logic       heat_mode;
        logic       heating_now;
    } hsfr_result_t;

endpackage

// ===== sv/hsfr_parser.sv =====
// Frame parser: start/end detection, frame byte capture and held status.
// Depends on hsfr_pkg and heater_status_frame_receiver_macros.svh.
`include "heater_status_frame_receiver_macros.svh"

module hsfr_parser #(
    parameter int FRAME_BYTES = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    output logic                 result_valid,
    output hsfr_pkg::hsfr_result_t result
);

    localparam int POS_W = $clog2(FRAME_BYTES + 1);

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    // Only the frame positions that are ever read are kept.
    logic [7:0]       tag_reg, tag_next;
    logic [7:0]       target_byte_reg, target_byte_next;
    logic [7:0]       current_byte_reg, current_byte_next;
    logic [7:0]       mode_byte_reg, mode_byte_next;
    logic [7:0]       action_byte_reg, action_byte_next;
    logic [7:0]       held_target_reg, held_target_next;
    logic [7:0]       held_current_reg, held_current_next;
    logic             held_mode_reg, held_mode_next;

    logic is_close, close_frame, store_byte, status_ok;

    always_comb begin
        is_close    = (rx_byte == hsfr_pkg::BYTE_END) || (rx_byte == hsfr_pkg::BYTE_LF);
        close_frame = step_en && in_frame_reg && is_close;
        store_byte  = step_en && in_frame_reg && !is_close
                      && (write_pos_reg < POS_W'(FRAME_BYTES));
        status_ok   = (tag_reg == hsfr_pkg::STATUS_TAG);

        in_frame_next = in_frame_reg;
        if (step_en) begin
            if (in_frame_reg) begin
                in_frame_next = !is_close;
            end else begin
                in_frame_next = (rx_byte == hsfr_pkg::BYTE_START);
            end
        end

        write_pos_next = write_pos_reg;
        if (close_frame) begin
            write_pos_next = '0;
        end else if (store_byte) begin
            write_pos_next = write_pos_reg + POS_W'(1);
        end

        tag_next          = tag_reg;
        target_byte_next  = target_byte_reg;
        current_byte_next = current_byte_reg;
        mode_byte_next    = mode_byte_reg;
        action_byte_next  = action_byte_reg;
        if (store_byte) begin
            if (write_pos_reg == POS_W'(hsfr_pkg::POS_TAG))     tag_next          = rx_byte;
            if (write_pos_reg == POS_W'(hsfr_pkg::POS_TARGET))  target_byte_next  = rx_byte;
            if (write_pos_reg == POS_W'(hsfr_pkg::POS_CURRENT)) current_byte_next = rx_byte;
            if (write_pos_reg == POS_W'(hsfr_pkg::POS_MODE))    mode_byte_next    = rx_byte;
            if (write_pos_reg == POS_W'(hsfr_pkg::POS_ACTION))  action_byte_next  = rx_byte;
        end

        held_target_next  = held_target_reg;
        held_current_next = held_current_reg;
        held_mode_next    = held_mode_reg;
        if (close_frame && status_ok) begin
            if (target_byte_reg != 8'h00)  held_target_next  = target_byte_reg;
            if (current_byte_reg != 8'h00) held_current_next = current_byte_reg;
            if (mode_byte_reg == hsfr_pkg::MODE_OFF_CODE) begin
                held_mode_next = 1'b0;
            end else if (mode_byte_reg == hsfr_pkg::MODE_HEAT_CODE) begin
                held_mode_next = 1'b1;
            end
        end

        result_valid        = close_frame && status_ok;
        result.target_temp  = held_target_next;
        result.current_temp = held_current_next;
        result.heat_mode    = held_mode_next;
        result.heating_now  = (action_byte_reg != 8'h00);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg     <= 1'b0;
            write_pos_reg    <= '0;
            tag_reg          <= 8'h00;
            target_byte_reg  <= 8'h00;
            current_byte_reg <= 8'h00;
            mode_byte_reg    <= 8'h00;
            action_byte_reg  <= 8'h00;
            held_target_reg  <= 8'h00;
            held_current_reg <= 8'h00;
            held_mode_reg    <= 1'b0;
        end else begin
            in_frame_reg     <= in_frame_next;
            write_pos_reg    <= write_pos_next;
            tag_reg          <= tag_next;
            target_byte_reg  <= target_byte_next;
            current_byte_reg <= current_byte_next;
            mode_byte_reg    <= mode_byte_next;
            action_byte_reg  <= action_byte_next;
            held_target_reg  <= held_target_next;
            held_current_reg <= held_current_next;
            held_mode_reg    <= held_mode_next;
        end
    end

    `HSFR_ASSERT_NEXT(a_close_rewinds, aclk, aresetn, close_frame,
                      !in_frame_reg && (write_pos_reg == '0))
    `HSFR_ASSERT_NOW(a_pos_bounded, aclk, aresetn, 1'b1,
                     write_pos_reg <= POS_W'(FRAME_BYTES))
    `HSFR_ASSERT_NOW(a_idle_pos_zero, aclk, aresetn, !in_frame_reg,
                     write_pos_reg == '0)

endmodule

// ===== sv/heater_status_frame_receiver.sv =====
// Top level of the heater status frame receiver: input and result registers.
// Depends on hsfr_pkg, hsfr_parser and heater_status_frame_receiver_macros.svh.
`include "heater_status_frame_receiver_macros.svh"

// Takes one received serial byte per transfer and reports the heater status
// carried in a frame: start byte 0x5A opens a frame, 0x5B or line feed closes
// it, and a closed frame whose byte 4 is 0xC9 yields one result with the held
// target and current temperatures, the held mode and the heating action.
// Frames without that tag close silently. Bytes beyond FRAME_BYTES are dropped,
// and positions a short frame does not reach keep older contents (zero after
// reset). Throughput is one byte per cycle while the result side is not
// stalled; a byte goes through an input register and the parse logic into
// the result register, and m_valid comes from that result register. The
// whole parse step, state update included, is combinational between the two
// registers, and a stalled result only holds the input side once both
// registers are full.
module heater_status_frame_receiver #(
    parameter int FRAME_BYTES = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_target_temp,
    output logic [7:0] m_current_temp,
    output logic       m_heat_mode,
    output logic       m_heating_now
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    hsfr_pkg::hsfr_result_t out_reg;

    logic                   process;
    logic                   result_valid;
    hsfr_pkg::hsfr_result_t result;

    // Advance the held byte whenever the result register can take its result.
    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    hsfr_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (process),
        .rx_byte     (in_byte_reg),
        .result_valid(result_valid),
        .result      (result)
    );

    always_comb begin
        // Hold the input register unless it drains or refills.
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end

        // Load a new result, otherwise drop the old one once it is taken.
        out_valid_next = out_valid_reg;
        if (process && result_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (process && result_valid) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_target_temp  = out_reg.target_temp;
    assign m_current_temp = out_reg.current_temp;
    assign m_heat_mode    = out_reg.heat_mode;
    assign m_heating_now  = out_reg.heating_now;

    `HSFR_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !process,
                      in_valid_reg && $stable(in_byte_reg))
    `HSFR_ASSERT_NEXT(a_result_loaded, aclk, aresetn, process && result_valid,
                      out_valid_reg)
    `HSFR_ASSERT_NEXT(a_out_stall_holds, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(out_reg))

endmodule
